// File: sv/sct_pkg.sv
// Shared types and codes for the S-expression character tokenizer.
`default_nettype none
package sct_pkg;

	localparam logic [2:0] KIND_LPAREN = 3'd0;
	localparam logic [2:0] KIND_RPAREN = 3'd1;
	localparam logic [2:0] KIND_NUMBER = 3'd2;
	localparam logic [2:0] KIND_SYMBOL = 3'd3;
	localparam logic [2:0] KIND_BAD    = 3'd4;
	localparam logic [2:0] KIND_END    = 3'd5;

	localparam logic [7:0] CH_TAB    = 8'd9;
	localparam logic [7:0] CH_LF     = 8'd10;
	localparam logic [7:0] CH_CR     = 8'd13;
	localparam logic [7:0] CH_SPACE  = 8'd32;
	localparam logic [7:0] CH_LPAREN = 8'd40;
	localparam logic [7:0] CH_RPAREN = 8'd41;
	localparam logic [7:0] CH_ZERO   = 8'd48;
	localparam logic [7:0] CH_NINE   = 8'd57;
	localparam logic [7:0] CH_SYM_HI = 8'd127;

	typedef enum logic [2:0] {
		MODE_IDLE   = 3'b001,
		MODE_NUMBER = 3'b010,
		MODE_SYMBOL = 3'b100
	} mode_t;

	typedef struct packed {
		logic [2:0] token_kind;
		logic [7:0] char_value;
		logic       carries_char;
		logic       token_done;
		logic       run_last;
	} result_t;

endpackage
`default_nettype wire

// File: sv/sct_decode.sv
// Character classification and scan-mode step: up to two result words per character.
`default_nettype none
module sct_decode (
	input  sct_pkg::mode_t   scan_mode,
	input  logic [7:0]       char_code,
	input  logic             end_of_input,
	output sct_pkg::result_t res0,
	output sct_pkg::result_t res1,
	output logic [1:0]       res_count,
	output sct_pkg::mode_t   next_mode
);
	import sct_pkg::*;

	logic    is_space;
	logic    is_num;
	logic    is_sym;
	logic    idle_has;
	result_t idle_res;
	mode_t   idle_mode;
	result_t close_res;
	logic    run_open;
	logic    run_cont;
	logic [2:0] run_kind;

	assign is_space = (char_code == CH_SPACE) || (char_code == CH_TAB) ||
		(char_code == CH_LF) || (char_code == CH_CR);
	assign is_num = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
	assign is_sym = (char_code > CH_SPACE) && (char_code <= CH_SYM_HI) &&
		(char_code != CH_LPAREN) && (char_code != CH_RPAREN);

	// handling of the character as seen from idle
	always_comb begin
		idle_has = 1'b1;
		idle_mode = MODE_IDLE;
		idle_res = '{token_kind: KIND_BAD, char_value: 8'd0, carries_char: 1'b0,
			token_done: 1'b1, run_last: 1'b1};
		if (end_of_input) begin
			idle_res.token_kind = KIND_END;
		end else if (is_space) begin
			idle_has = 1'b0;
		end else if (char_code == CH_LPAREN) begin
			idle_res.token_kind = KIND_LPAREN;
		end else if (char_code == CH_RPAREN) begin
			idle_res.token_kind = KIND_RPAREN;
		end else if (is_num) begin
			idle_res.token_kind = KIND_NUMBER;
			idle_res.char_value = char_code;
			idle_res.carries_char = 1'b1;
			idle_res.token_done = 1'b0;
			idle_mode = MODE_NUMBER;
		end else if (is_sym) begin
			idle_res.token_kind = KIND_SYMBOL;
			idle_res.char_value = char_code;
			idle_res.carries_char = 1'b1;
			idle_res.token_done = 1'b0;
			idle_mode = MODE_SYMBOL;
		end
	end

	always_comb begin
		run_open = 1'b0;
		run_cont = 1'b0;
		run_kind = KIND_NUMBER;
		unique case (scan_mode)
			MODE_NUMBER: begin
				run_open = 1'b1;
				run_cont = !end_of_input && is_num;
			end
			MODE_SYMBOL: begin
				run_open = 1'b1;
				run_cont = !end_of_input && is_sym;
				run_kind = KIND_SYMBOL;
			end
			default: begin
				run_open = 1'b0;
			end
		endcase
	end

	assign close_res = '{token_kind: run_kind, char_value: 8'd0, carries_char: 1'b0,
		token_done: 1'b1, run_last: !idle_has};

	always_comb begin
		res0 = idle_res;
		res1 = idle_res;
		res_count = {1'b0, idle_has};
		next_mode = idle_mode;
		if (run_open && run_cont) begin
			res0 = '{token_kind: run_kind, char_value: char_code, carries_char: 1'b1,
				token_done: 1'b0, run_last: 1'b1};
			res_count = 2'd1;
			next_mode = scan_mode;
		end else if (run_open) begin
			res0 = close_res;
			res_count = idle_has ? 2'd2 : 2'd1;
		end
	end

endmodule
`default_nettype wire

// File: sv/sexpr_char_tokenizer.sv
// Channel   | Direction | Handshake               | Payload
// char      | in        | char_valid / char_stall | char_code, end_of_input
// tok       | out       | tok_valid / tok_stall   | token_kind, char_value, carries_char,
//           |           |                         | token_done, run_last
// One input register, decode logic, one output register. A character that gives at
// most one word moves through at one word per cycle unless the output stalls; one that
// closes a run and gives a word of its own gives two words and holds the input
// register until its second word is loaded. Reset returns the scan mode to idle and
// empties both registers. A stalled output holds the input register unless its character gives none.
`default_nettype none
module sexpr_char_tokenizer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       char_valid,
	output logic       char_stall,
	input  logic [7:0] char_code,
	input  logic       end_of_input,
	output logic       tok_valid,
	input  logic       tok_stall,
	output logic [2:0] token_kind,
	output logic [7:0] char_value,
	output logic       carries_char,
	output logic       token_done,
	output logic       run_last
);
	import sct_pkg::*;

	logic       vld_s1;
	logic [7:0] char_s1;
	logic       eoi_s1;
	logic       half_q;
	mode_t      mode_q;
	logic       out_vld_s2;
	result_t    out_s2;

	result_t    res0;
	result_t    res1;
	logic [1:0] res_count;
	mode_t      next_mode;
	logic       load_ok;
	logic       emit;
	logic       done_s1;
	logic       accept;

	sct_decode u_decode (
		.scan_mode    (mode_q),
		.char_code    (char_s1),
		.end_of_input (eoi_s1),
		.res0         (res0),
		.res1         (res1),
		.res_count    (res_count),
		.next_mode    (next_mode)
	);

	assign load_ok = !out_vld_s2 || !tok_stall;
	assign emit = vld_s1 && (res_count != 2'd0) && load_ok;
	// item leaves stage 1 once its last word is loaded, or at once if it gives none
	assign done_s1 = vld_s1 && ((res_count == 2'd0) ||
		(load_ok && (half_q || (res_count == 2'd1))));
	assign char_stall = vld_s1 && !done_s1;
	assign accept = char_valid && !char_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			half_q <= 1'b0;
			mode_q <= MODE_IDLE;
			out_vld_s2 <= 1'b0;
		end else begin
			if (accept) begin
				vld_s1 <= 1'b1;
			end else if (done_s1) begin
				vld_s1 <= 1'b0;
			end
			if (done_s1) begin
				half_q <= 1'b0;
				mode_q <= next_mode;
			end else if (emit) begin
				half_q <= 1'b1;
			end
			if (load_ok) begin
				out_vld_s2 <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			char_s1 <= char_code;
			eoi_s1 <= end_of_input;
		end
		if (emit) begin
			out_s2 <= half_q ? res1 : res0;
		end
	end

	assign tok_valid = out_vld_s2;
	assign token_kind = out_s2.token_kind;
	assign char_value = out_s2.char_value;
	assign carries_char = out_s2.carries_char;
	assign token_done = out_s2.token_done;
	assign run_last = out_s2.run_last;

`ifndef SYNTH
	a_half_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		half_q |-> vld_s1)
		else $error("second word pending without an item in stage 1");

	a_half_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		half_q |-> (mode_q == MODE_NUMBER || mode_q == MODE_SYMBOL))
		else $error("two-word item without an open run");

	a_second_word_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(tok_valid && !tok_stall && !run_last) |=> tok_valid)
		else $error("second word of an item did not follow the first");

	a_char_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(tok_valid && carries_char) |->
		(token_kind == KIND_NUMBER || token_kind == KIND_SYMBOL))
		else $error("character word with a kind other than number or symbol");
`endif

endmodule
`default_nettype wire
